/* rtl/core/rclt_pkg.sv */
// Shared types and constants for the row centroid line tracker.
// No dependencies; imported by every module of the block.
package rclt_pkg;

	localparam int MAX_WIDTH_DEF     = 2048;
	localparam int MAX_HEIGHT_DEF    = 1024;
	localparam int FRACTION_BITS_DEF = 4;

	localparam int MEAN_W = 15;
	localparam int ROW_W  = 10;

	localparam int CMD_FIFO_DEPTH = 4;

	typedef enum logic [1:0] {
		CMD_CLEAR,
		CMD_PUSH,
		CMD_POP
	} cmd_kind_t;

	// clr on a push: empty the stack before the row result is stored
	typedef struct packed {
		cmd_kind_t kind;
		logic      clr;
	} cmd_ctl_t;

	localparam int CTL_W = $bits(cmd_ctl_t);

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_WRITE,
		B_READ
	} back_state_t;

endpackage

/* rtl/core/row_centroid_line_tracker_unit.sv */
// Top level of the row centroid line tracker.
// Depends on rclt_pkg, rclt_front, rclt_cmd_fifo and rclt_back.
//
// Input channel (in_valid / in_stall): a raster stream of mask pixels
// (action = 0) with end_of_row on the last pixel of each row and
// start_of_frame on the first pixel of a frame, mixed with pop requests
// (action = 1). Each finished row with set pixels stores its mean column
// (FRACTION_BITS fraction bits, truncated) and row index on a stack.
// Output channel (out_valid / out_stall): one transfer per pop, last row first;
// entry_valid = 0 when the stack was empty, last_entry marks the final entry.
// Throughput: plain pixels are taken every cycle. End-of-row, start-of-frame
// and pop items stall while the 4-entry command queue is full; pops, frame
// starts and ends of rows with set pixels enter it as commands. The back end
// runs a stored row through the divider (one quotient bit per cycle) and then
// writes it to the stack, and empties the stack on a clear; a pop reads the
// stack and loads the output register, or loads an empty-stack result.
// Reset empties the queue, the stack and the row accumulators; stack entries
// need no clearing pass. A stalled output holds its result and holds the pop
// queue behind it; pixel accumulation goes on.
module row_centroid_line_tracker_unit #(
	parameter int MAX_WIDTH     = rclt_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT    = rclt_pkg::MAX_HEIGHT_DEF,
	parameter int FRACTION_BITS = rclt_pkg::FRACTION_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        action,
	input  logic [7:0]                  pixel_value,
	input  logic                        end_of_row,
	input  logic                        start_of_frame,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        entry_valid,
	output logic [rclt_pkg::MEAN_W-1:0] mean_column,
	output logic [rclt_pkg::ROW_W-1:0]  row_number,
	output logic                        last_entry
);
	import rclt_pkg::*;

	localparam int CW    = $clog2(MAX_WIDTH + 1);
	localparam int SW    = 2 * CW;
	localparam int RW    = $clog2(MAX_HEIGHT + 1);
	localparam int CMD_W = CTL_W + SW + CW + RW;

	fifo_stat_t       fifo_stat;
	logic             cmd_push, cmd_pop;
	logic [CMD_W-1:0] cmd_in, cmd_out;

	rclt_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.pixel_value    (pixel_value),
		.end_of_row     (end_of_row),
		.start_of_frame (start_of_frame),
		.fifo_stat      (fifo_stat),
		.cmd_push       (cmd_push),
		.cmd_data       (cmd_in)
	);

	rclt_cmd_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (CMD_FIFO_DEPTH)
	) u_cmd_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd_in),
		.pop       (cmd_pop),
		.pop_data  (cmd_out),
		.stat      (fifo_stat)
	);

	rclt_back #(
		.MAX_WIDTH     (MAX_WIDTH),
		.MAX_HEIGHT    (MAX_HEIGHT),
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.fifo_stat   (fifo_stat),
		.cmd_data    (cmd_out),
		.cmd_pop     (cmd_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.entry_valid (entry_valid),
		.mean_column (mean_column),
		.row_number  (row_number),
		.last_entry  (last_entry)
	);

	// front end never writes a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !fifo_stat.full)
		else $error("command written into a full queue");

	// back end never reads an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !fifo_stat.empty)
		else $error("command taken from an empty queue");

	a_last_is_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_entry) |-> entry_valid)
		else $error("last_entry flagged on an empty-stack result");

endmodule

/* rtl/core/rclt_front.sv */
// Front end: accepts pixel and pop items, accumulates the row, issues commands.
// Depends on rclt_pkg; feeds rclt_cmd_fifo.
module rclt_front #(
	parameter int MAX_WIDTH  = rclt_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rclt_pkg::MAX_HEIGHT_DEF,
	localparam int CW    = $clog2(MAX_WIDTH + 1),
	localparam int SW    = 2 * CW,
	localparam int RW    = $clog2(MAX_HEIGHT + 1),
	localparam int CMD_W = rclt_pkg::CTL_W + SW + CW + RW
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   action,
	input  logic [7:0]             pixel_value,
	input  logic                   end_of_row,
	input  logic                   start_of_frame,
	input  rclt_pkg::fifo_stat_t   fifo_stat,
	output logic                   cmd_push,
	output logic [CMD_W-1:0]       cmd_data
);
	import rclt_pkg::*;

	logic [CW-1:0] col_q, col_d, col_c;
	logic [RW-1:0] row_q, row_d, row_c;
	logic [SW-1:0] sum_q, sum_d, sum_c;
	logic [CW-1:0] cnt_q, cnt_d, cnt_c;
	logic [SW-1:0] row_sum;
	logic [CW-1:0] row_cnt;
	logic          accept;
	logic          push_row;
	cmd_ctl_t      ctl;

	// plain pixel items, without end_of_row or start_of_frame, never wait on the queue
	assign in_stall = fifo_stat.full && (action || end_of_row || start_of_frame);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		col_c = start_of_frame ? '0 : col_q;
		row_c = start_of_frame ? '0 : row_q;
		sum_c = start_of_frame ? '0 : sum_q;
		cnt_c = start_of_frame ? '0 : cnt_q;
		col_d = col_c;
		row_d = row_c;
		sum_d = sum_c;
		cnt_d = cnt_c;
		push_row = 1'b0;
		if (col_c < CW'(MAX_WIDTH)) begin
			if (pixel_value != 8'd0 && row_c < RW'(MAX_HEIGHT)) begin
				sum_d = sum_c + SW'(col_c);
				cnt_d = cnt_c + 1'b1;
			end
			col_d = col_c + 1'b1;
		end
		// totals of the row including this pixel
		row_sum = sum_d;
		row_cnt = cnt_d;
		if (end_of_row) begin
			push_row = (row_cnt != '0) && (row_c < RW'(MAX_HEIGHT));
			if (row_c < RW'(MAX_HEIGHT))
				row_d = row_c + 1'b1;
			col_d = '0;
			sum_d = '0;
			cnt_d = '0;
		end
	end

	always_comb begin
		ctl.clr  = 1'b0;
		ctl.kind = CMD_CLEAR;
		cmd_push = 1'b0;
		if (accept) begin
			if (action) begin
				ctl.kind = CMD_POP;
				cmd_push = 1'b1;
			end else if (push_row) begin
				ctl.kind = CMD_PUSH;
				ctl.clr  = start_of_frame;
				cmd_push = 1'b1;
			end else if (start_of_frame) begin
				ctl.kind = CMD_CLEAR;
				cmd_push = 1'b1;
			end
		end
	end

	// row index of the finished row is the one before the advance
	assign cmd_data = {ctl, row_sum, row_cnt, row_c};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
		end else if (accept && !action) begin
			col_q <= col_d;
			row_q <= row_d;
			sum_q <= sum_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

/* rtl/core/rclt_cmd_fifo.sv */
// Short command queue between front end and back end.
// Depends on rclt_pkg for the status struct.
module rclt_cmd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = rclt_pkg::CMD_FIFO_DEPTH,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNTW = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [WIDTH-1:0]     push_data,
	input  logic                 pop,
	output logic [WIDTH-1:0]     pop_data,
	output rclt_pkg::fifo_stat_t stat
);
	import rclt_pkg::*;

	logic [WIDTH-1:0] slots_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_push, do_pop;

	assign stat.full  = (count_q == CNTW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_data   = slots_q[rd_ptr_q];

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push)
			slots_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

/* rtl/core/rclt_back.sv */
// Back end: divides row sums, keeps the result stack, serves pops.
// Depends on rclt_pkg; drains rclt_cmd_fifo and drives the output channel.
module rclt_back #(
	parameter int MAX_WIDTH     = rclt_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT    = rclt_pkg::MAX_HEIGHT_DEF,
	parameter int FRACTION_BITS = rclt_pkg::FRACTION_BITS_DEF,
	localparam int CW    = $clog2(MAX_WIDTH + 1),
	localparam int SW    = 2 * CW,
	localparam int RW    = $clog2(MAX_HEIGHT + 1),
	localparam int CMD_W = rclt_pkg::CTL_W + SW + CW + RW
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rclt_pkg::fifo_stat_t          fifo_stat,
	input  logic [CMD_W-1:0]              cmd_data,
	output logic                          cmd_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          entry_valid,
	output logic [rclt_pkg::MEAN_W-1:0]   mean_column,
	output logic [rclt_pkg::ROW_W-1:0]    row_number,
	output logic                          last_entry
);
	import rclt_pkg::*;

	localparam int DW    = SW + FRACTION_BITS;
	localparam int STW   = $clog2(DW);
	localparam int AW    = $clog2(MAX_HEIGHT);
	localparam int ENT_W = MEAN_W + ROW_W;

	back_state_t     state_q, state_d;
	cmd_ctl_t        ctl;
	logic [SW-1:0]   cmd_sum;
	logic [CW-1:0]   cmd_cnt;
	logic [RW-1:0]   cmd_row;

	logic [RW-1:0]   sp_q, sp_m1;
	logic [DW-1:0]   dvd_q, dvd_n;
	logic [CW-1:0]   rem_q, rem_n, dsr_q;
	logic [CW:0]     trial;
	logic            ge;
	logic [STW-1:0]  step_q;
	logic [RW-1:0]   row_q;

	logic [ENT_W-1:0] stack_mem [MAX_HEIGHT];
	logic [ENT_W-1:0] rd_data_q;
	logic             rd_last_q;

	logic out_free, div_load, wr_en, rd_en, load_empty, load_mem;
	logic sp_clear, sp_inc, sp_dec;

	assign ctl     = cmd_ctl_t'(cmd_data[CMD_W-1 -: CTL_W]);
	assign cmd_sum = cmd_data[RW+CW+SW-1:RW+CW];
	assign cmd_cnt = cmd_data[RW+CW-1:RW];
	assign cmd_row = cmd_data[RW-1:0];

	assign sp_m1    = sp_q - 1'b1;
	assign out_free = !out_valid || !out_stall;

	// one restoring step: quotient bits shift in from the bottom of dvd
	assign trial = {rem_q, dvd_q[DW-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign rem_n = ge ? CW'(trial - {1'b0, dsr_q}) : trial[CW-1:0];
	assign dvd_n = {dvd_q[DW-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= B_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		cmd_pop    = 1'b0;
		div_load   = 1'b0;
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		load_empty = 1'b0;
		load_mem   = 1'b0;
		sp_clear   = 1'b0;
		sp_inc     = 1'b0;
		sp_dec     = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!fifo_stat.empty) begin
					case (ctl.kind)
						CMD_CLEAR: begin
							cmd_pop  = 1'b1;
							sp_clear = 1'b1;
						end
						CMD_PUSH: begin
							cmd_pop  = 1'b1;
							sp_clear = ctl.clr;
							div_load = 1'b1;
							state_d  = B_DIV;
						end
						CMD_POP: begin
							if (out_free) begin
								cmd_pop = 1'b1;
								if (sp_q == '0) begin
									load_empty = 1'b1;
								end else begin
									rd_en   = 1'b1;
									sp_dec  = 1'b1;
									state_d = B_READ;
								end
							end
						end
						default: begin
							cmd_pop = 1'b1;
						end
					endcase
				end
			end
			B_DIV: begin
				if (step_q == STW'(DW - 1))
					state_d = B_WRITE;
			end
			B_WRITE: begin
				// drop the push when the stack is full
				if (sp_q != RW'(MAX_HEIGHT)) begin
					wr_en  = 1'b1;
					sp_inc = 1'b1;
				end
				state_d = B_IDLE;
			end
			B_READ: begin
				load_mem = 1'b1;
				state_d  = B_IDLE;
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (div_load) begin
			dvd_q  <= DW'(cmd_sum) << FRACTION_BITS;
			rem_q  <= '0;
			dsr_q  <= cmd_cnt;
			row_q  <= cmd_row;
			step_q <= '0;
		end else if (state_q == B_DIV) begin
			dvd_q  <= dvd_n;
			rem_q  <= rem_n;
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			stack_mem[sp_q[AW-1:0]] <= {MEAN_W'(dvd_q), ROW_W'(row_q)};
		if (rd_en) begin
			rd_data_q <= stack_mem[sp_m1[AW-1:0]];
			rd_last_q <= (sp_m1 == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sp_q <= '0;
		else if (sp_clear)
			sp_q <= '0;
		else if (sp_inc)
			sp_q <= sp_q + 1'b1;
		else if (sp_dec)
			sp_q <= sp_m1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (load_empty || load_mem)
			out_valid <= 1'b1;
		else if (out_valid && !out_stall)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_empty) begin
			entry_valid <= 1'b0;
			mean_column <= '0;
			row_number  <= '0;
			last_entry  <= 1'b0;
		end else if (load_mem) begin
			entry_valid <= 1'b1;
			mean_column <= rd_data_q[ENT_W-1:ROW_W];
			row_number  <= rd_data_q[ROW_W-1:0];
			last_entry  <= rd_last_q;
		end
	end

endmodule

/* dv/tb_row_centroid_line_tracker_unit.sv */
// Testbench for row_centroid_line_tracker_unit: pixel/pop stream in, pop results out.
// Tracks the row centroid stack in a local predictor and checks every pop result.
// Depends on rclt_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_row_centroid_line_tracker_unit;
	import rclt_pkg::*;

	localparam int MAX_W       = MAX_WIDTH_DEF;
	localparam int MAX_H       = MAX_HEIGHT_DEF;
	localparam int FRAC        = FRACTION_BITS_DEF;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 64;

	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_POP   = 1'b1;

	typedef struct packed {
		logic              entry_valid;
		logic [MEAN_W-1:0] mean;
		logic [ROW_W-1:0]  row;
		logic              last;
	} pop_result_t;

	typedef struct packed {
		logic        act;
		logic [7:0]  pix;
		logic        eor;
		logic        sof;
		logic        typed;
		pop_result_t want;
	} directed_row_t;

	localparam pop_result_t NO_RESULT = '0;
	localparam pop_result_t EMPTY_POP = '0;

	logic                clk;
	logic                arst_n         = 1'b0;
	logic                in_valid       = 1'b0;
	logic                in_stall;
	logic                action         = ACT_PIXEL;
	logic [7:0]          pixel_value    = 8'd0;
	logic                end_of_row     = 1'b0;
	logic                start_of_frame = 1'b0;
	logic                out_valid;
	logic                out_stall;
	logic                entry_valid;
	logic [MEAN_W-1:0]   mean_column;
	logic [ROW_W-1:0]    row_number;
	logic                last_entry;

	// predictor state
	int unsigned       col_pos;
	int unsigned       row_idx;
	longint unsigned   col_total;
	int unsigned       set_pixels;
	int unsigned       depth;
	logic [MEAN_W-1:0] saved_mean [MAX_H];
	logic [ROW_W-1:0]  saved_row  [MAX_H];

	pop_result_t expected_pops[$];
	int          mismatch_count = 0;
	int          items_sent     = 0;
	int          send_idle_pct  = 0;
	int          recv_idle_pct  = 0;
	int          hold_requests  = 0;

	// popping from the top returns rows last first; sof on a pop is ignored
	directed_row_t directed_rows [0:21] = '{
		'{ACT_POP,   8'hFF, 1'b1, 1'b1, 1'b1, EMPTY_POP},
		'{ACT_PIXEL, 8'h00, 1'b0, 1'b1, 1'b0, NO_RESULT},
		'{ACT_PIXEL, 8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{ACT_PIXEL, 8'h01, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{ACT_PIXEL, 8'h80, 1'b1, 1'b0, 1'b0, NO_RESULT},
		'{ACT_PIXEL, 8'h00, 1'b1, 1'b0, 1'b0, NO_RESULT},
		'{ACT_PIXEL, 8'h55, 1'b1, 1'b0, 1'b0, NO_RESULT},
		'{ACT_PIXEL, 8'hAA, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{ACT_PIXEL, 8'h01, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{ACT_PIXEL, 8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{ACT_PIXEL, 8'h7F, 1'b1, 1'b0, 1'b0, NO_RESULT},
		'{ACT_PIXEL, 8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{ACT_POP,   8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{ACT_PIXEL, 8'h01, 1'b1, 1'b0, 1'b0, NO_RESULT},
		'{ACT_POP,   8'h5A, 1'b0, 1'b1, 1'b0, NO_RESULT},
		'{ACT_POP,   8'hA5, 1'b1, 1'b0, 1'b1, '{1'b1, 15'd0, 10'd2, 1'b0}},
		'{ACT_POP,   8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{ACT_POP,   8'hFF, 1'b1, 1'b1, 1'b1, EMPTY_POP},
		'{ACT_PIXEL, 8'hFE, 1'b1, 1'b1, 1'b0, NO_RESULT},
		'{ACT_PIXEL, 8'h02, 1'b1, 1'b1, 1'b0, NO_RESULT},
		'{ACT_POP,   8'h00, 1'b0, 1'b0, 1'b1, '{1'b1, 15'd0, 10'd0, 1'b1}},
		'{ACT_POP,   8'h00, 1'b0, 1'b0, 1'b1, EMPTY_POP}
	};

	row_centroid_line_tracker_unit uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.pixel_value    (pixel_value),
		.end_of_row     (end_of_row),
		.start_of_frame (start_of_frame),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.entry_valid    (entry_valid),
		.mean_column    (mean_column),
		.row_number     (row_number),
		.last_entry     (last_entry)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("tb: mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic clear_tracker();
		col_pos    = 0;
		row_idx    = 0;
		col_total  = 0;
		set_pixels = 0;
		depth      = 0;
	endtask

	// advance the predictor by one accepted transfer
	task automatic track_item(input logic act, input logic [7:0] pix, input logic eor,
			input logic sof);
		pop_result_t     res;
		longint unsigned quotient;
		if (act == ACT_POP) begin
			res = '0;
			if (depth > 0) begin
				depth--;
				res.entry_valid = 1'b1;
				res.mean        = saved_mean[depth];
				res.row         = saved_row[depth];
				res.last        = (depth == 0);
			end
			expected_pops.push_back(res);
		end else begin
			if (sof)
				clear_tracker();
			if (col_pos < MAX_W) begin
				if (pix != 8'd0 && row_idx < MAX_H) begin
					col_total += col_pos;
					set_pixels++;
				end
				col_pos++;
			end
			if (eor) begin
				if (set_pixels > 0 && row_idx < MAX_H && depth < MAX_H) begin
					quotient          = (col_total << FRAC) / set_pixels;
					saved_mean[depth] = MEAN_W'(quotient);
					saved_row[depth]  = ROW_W'(row_idx);
					depth++;
				end
				if (row_idx < MAX_H)
					row_idx++;
				col_pos    = 0;
				col_total  = 0;
				set_pixels = 0;
			end
		end
	endtask

	task automatic offer(input logic act, input logic [7:0] pix, input logic eor,
			input logic sof);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		action         <= act;
		pixel_value    <= pix;
		end_of_row     <= eor;
		start_of_frame <= sof;
		do @(posedge clk); while (in_stall !== 1'b0);
		track_item(act, pix, eor, sof);
		items_sent++;
	endtask

	task automatic offer_pop();
		offer(ACT_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
	endtask

	// drop valid and hold until every pop result has come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_pops.size() != 0)
			@(posedge clk);
	endtask

	task automatic offer_noise();
		logic       act;
		logic [7:0] pix;
		act = ($urandom_range(0, 99) < 20) ? ACT_POP : ACT_PIXEL;
		pix = ($urandom_range(0, 99) < 30) ? 8'd0 : 8'($urandom_range(0, 255));
		offer(act, pix, $urandom_range(0, 99) < 30, $urandom_range(0, 99) < 15);
	endtask

	task automatic random_frame();
		int         rows;
		int         width;
		int         density;
		logic [7:0] pix;
		rows = $urandom_range(1, 8);
		for (int r = 0; r < rows; r++) begin
			width   = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 200)
				: $urandom_range(1, 24);
			density = $urandom_range(0, 3) * 33;
			for (int i = 0; i < width; i++) begin
				if ($urandom_range(0, 99) < 12)
					offer_pop();
				pix = ($urandom_range(0, 99) < density) ? 8'($urandom_range(1, 255)) : 8'd0;
				offer(ACT_PIXEL, pix, i == width - 1, r == 0 && i == 0);
			end
		end
		repeat ($urandom_range(0, 6))
			offer_pop();
	endtask

	task automatic random_phase(input int count);
		int goal;
		goal = items_sent + count;
		while (items_sent < goal) begin
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 12))
					offer_noise();
			else
				random_frame();
		end
	endtask

	// only the last legal column is set, so the mean hits its top value;
	// set pixels past the width limit must not count
	task automatic wide_row();
		for (int c = 0; c < MAX_W + 20; c++)
			offer(ACT_PIXEL, (c >= MAX_W - 1) ? 8'($urandom_range(1, 255)) : 8'd0,
				c == MAX_W + 19, c == 0);
		offer_pop();
	endtask

	// fill the stack with every legal row, run past the row limit, then empty it
	task automatic tall_frame();
		int width;
		for (int r = 0; r < MAX_H + 6; r++) begin
			width = $urandom_range(1, 3);
			for (int i = 0; i < width; i++)
				offer(ACT_PIXEL, (i == 0) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(0, 255)),
					i == width - 1, r == 0 && i == 0);
		end
		repeat (MAX_H + 1)
			offer_pop();
	endtask

	initial begin
		int hold_left;
		int seen_hold;
		hold_left = 0;
		seen_hold = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != seen_hold) begin
				seen_hold = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		pop_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_pops.size() == 0)
				report_mismatch($sformatf("result with nothing pending, row %0d", row_number));
			else begin
				want = expected_pops.pop_front();
				if (entry_valid !== want.entry_valid)
					report_mismatch($sformatf("entry_valid %b, want %b", entry_valid,
						want.entry_valid));
				if (mean_column !== want.mean)
					report_mismatch($sformatf("mean_column %0d, want %0d", mean_column, want.mean));
				if (row_number !== want.row)
					report_mismatch($sformatf("row_number %0d, want %0d", row_number, want.row));
				if (last_entry !== want.last)
					report_mismatch($sformatf("last_entry %b, want %b", last_entry, want.last));
			end
		end
	end

	initial begin
		clear_tracker();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 24;
		recv_idle_pct = 67;
		foreach (directed_rows[k]) begin
			offer(directed_rows[k].act, directed_rows[k].pix, directed_rows[k].eor,
				directed_rows[k].sof);
			if (directed_rows[k].typed)
				expected_pops[expected_pops.size() - 1] = directed_rows[k].want;
		end
		drain();

		wide_row();
		tall_frame();
		drain();
		random_phase(500);
		drain();

		send_idle_pct = 67;
		recv_idle_pct = 24;
		random_phase(500);
		drain();

		// long output hold-off while pops keep coming: queue fills, input stalls
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests++;
		repeat (20)
			offer_pop();
		random_phase(500);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
